### sv/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
// Checks compile only when SYNTHESIS is not defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define AST_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: implication");
// Next-cycle implication.
`define AST_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");
`else
`define AST_IMPLY(label, clk, rst_n, a, b)
`define AST_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### sv/ovn_pkg.sv
// Package for the octave value noise block: sizes, codes, FSM state,
// and controller/datapath command and status types. No dependencies.
package ovn_pkg;

    localparam int SIDE_LG   = 7;
    localparam int SIDE      = 1 << SIDE_LG;
    localparam int SEED_W    = 16;
    localparam int ADDR_W    = 2 * SIDE_LG;
    localparam int OCT_W     = 3;
    localparam int BIAS_W    = 16;
    localparam int WFRAC     = 24;
    localparam int WGT_W     = 38;
    localparam int TOT_W     = 39;
    localparam int SUM_W     = 56;
    localparam int DVD_W     = 56;
    localparam int DVR_W     = 40;
    localparam int PITCH_W   = SIDE_LG + 1;

    localparam logic [BIAS_W-1:0] BIAS_MIN   = 16'd819;
    localparam logic [BIAS_W-1:0] BIAS_RESET = 16'd8192;
    localparam logic [OCT_W-1:0]  OCT_RESET  = 3'd5;

    // Opcodes and configuration register indexes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic CFG_OCTAVES = 1'b0;
    localparam logic CFG_BIAS    = 1'b1;

    // Corner order: (x1,y1) (x2,y1) (x1,y2) (x2,y2)
    localparam logic [1:0] CRN_11 = 2'd0;
    localparam logic [1:0] CRN_12 = 2'd1;
    localparam logic [1:0] CRN_21 = 2'd2;
    localparam logic [1:0] CRN_22 = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RDL,
        ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_ACC, ST_WDIV,
        ST_FDIV, ST_FWAIT, ST_OUT
    } t_state;

    typedef struct packed {
        logic       wr_seed;
        logic       load;
        logic [1:0] rd_idx;
        logic       rd_en;
        logic       cap_en;
        logic [1:0] cap_idx;
        logic       m1;
        logic       m2;
        logic       m3;
        logic       m4;
        logic       m5;
        logic       acc;
        logic       wstep;
        logic       fstart;
        logic       flatch;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic last_oct;
    } t_dp_stat;

endpackage

### sv/ovn_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module ovn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/ovn_div.sv
// Restoring divider, one quotient bit per cycle, DVD_W quotient bits a division.
// Depends on ovn_pkg.
module ovn_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ovn_pkg::DVD_W-1:0]  i_dividend,
    input  logic [ovn_pkg::DVR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [ovn_pkg::DVD_W-1:0]  o_quot
);
    import ovn_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic [DVD_W-1:0] r_dvd;
    logic [DVR_W-1:0] r_dvr;
    logic [DVR_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVR_W:0]   trial;
    logic             qbit;

    // One restoring step
    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        qbit  = (trial >= {1'b0, r_dvr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= qbit ? DVR_W'(trial - {1'b0, r_dvr}) : trial[DVR_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
endmodule

### sv/ovn_dp.sv
// Datapath: seed RAM, configuration registers, bilinear interpolation,
// weight accumulation and the shared divider. Depends on ovn_pkg, ovn_ram, ovn_div.
module ovn_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ovn_pkg::t_dp_cmd            i_cmd,
    output ovn_pkg::t_dp_stat           o_stat,
    input  logic [ovn_pkg::SIDE_LG-1:0] i_pos_x,
    input  logic [ovn_pkg::SIDE_LG-1:0] i_pos_y,
    input  logic [ovn_pkg::SEED_W-1:0]  i_seed_value,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [ovn_pkg::BIAS_W-1:0]  i_cfg_data,
    output logic [ovn_pkg::SEED_W-1:0]  o_noise_value,
    output logic [ovn_pkg::SIDE_LG-1:0] o_out_x,
    output logic [ovn_pkg::SIDE_LG-1:0] o_out_y
);
    import ovn_pkg::*;

    logic [OCT_W-1:0]   r_oct_cfg;
    logic [BIAS_W-1:0]  r_bias_cfg;
    logic [SIDE_LG-1:0] r_x, r_y;
    logic [OCT_W-1:0]   r_oct;
    logic [SEED_W-1:0]  r_s [4];
    logic [23:0]        r_pa, r_pb, r_pc, r_pd;
    logic [23:0]        r_top, r_bot;
    logic [31:0]        r_pe, r_pf;
    logic [SEED_W-1:0]  r_smp;
    logic [53:0]        r_prod;
    logic [WGT_W-1:0]   r_wgt;
    logic [TOT_W-1:0]   r_tot;
    logic [SUM_W-1:0]   r_sum;
    logic [SEED_W-1:0]  r_noise;

    logic [OCT_W-1:0]   octs, oct_last;
    logic [BIAS_W-1:0]  bias;
    logic [PITCH_W-1:0] pitch, pdx, pdy;
    logic [SIDE_LG-1:0] mask, x1, y1, x2, y2, dx, dy, cx, cy;
    logic [4:0]         shamt;
    logic [31:0]        lerp;
    logic [ADDR_W-1:0]  addr;
    logic [SEED_W-1:0]  rdata;
    logic               div_start, div_done;
    logic [DVD_W-1:0]   div_dvd, div_q;
    logic [DVR_W-1:0]   div_dvr;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct_cfg  <= OCT_RESET;
            r_bias_cfg <= BIAS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_OCTAVES) begin
                r_oct_cfg <= i_cfg_data[OCT_W-1:0];
            end else begin
                r_bias_cfg <= i_cfg_data;
            end
        end
    end

    // Clamped settings
    assign octs     = (r_oct_cfg == '0) ? OCT_W'(1) : r_oct_cfg;
    assign oct_last = octs - 1'b1;
    assign bias     = (r_bias_cfg < BIAS_MIN) ? BIAS_MIN : r_bias_cfg;

    // Cell corners for the current octave; pitch is a power of two
    always_comb begin
        pitch = PITCH_W'(SIDE) >> r_oct;
        mask  = SIDE_LG'(pitch - 1'b1);
        dx    = r_x & mask;
        dy    = r_y & mask;
        x1    = r_x & ~mask;
        y1    = r_y & ~mask;
        x2    = SIDE_LG'({1'b0, x1} + pitch);
        y2    = SIDE_LG'({1'b0, y1} + pitch);
        pdx   = pitch - {1'b0, dx};
        pdy   = pitch - {1'b0, dy};
        shamt = 5'(2 * (SIDE_LG - int'(r_oct)));
        unique case (i_cmd.rd_idx)
            CRN_11:  begin cx = x1; cy = y1; end
            CRN_12:  begin cx = x2; cy = y1; end
            CRN_21:  begin cx = x1; cy = y2; end
            default: begin cx = x2; cy = y2; end
        endcase
    end

    assign addr = i_cmd.wr_seed ? {i_pos_y, i_pos_x} : {cy, cx};

    ovn_ram #(.WIDTH(SEED_W), .DEPTH(SIDE * SIDE)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_seed),
        .i_addr  (addr),
        .i_wdata (i_seed_value),
        .o_rdata (rdata)
    );

    assign lerp = r_pe + r_pf;

    // Interpolation pipeline, one step per command
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_pos_x;
            r_y <= i_pos_y;
        end
        if (i_cmd.cap_en) begin
            r_s[i_cmd.cap_idx] <= rdata;
        end
        if (i_cmd.m1) begin
            r_pa <= 24'(pdx * r_s[CRN_11]);
            r_pb <= 24'({1'b0, dx} * r_s[CRN_12]);
            r_pc <= 24'(pdx * r_s[CRN_21]);
            r_pd <= 24'({1'b0, dx} * r_s[CRN_22]);
        end
        if (i_cmd.m2) begin
            r_top <= r_pa + r_pb;
            r_bot <= r_pc + r_pd;
        end
        if (i_cmd.m3) begin
            r_pe <= 32'(pdy * r_top);
            r_pf <= 32'({1'b0, dy} * r_bot);
        end
        if (i_cmd.m4) begin
            r_smp <= SEED_W'(lerp >> shamt);
        end
        if (i_cmd.m5) begin
            r_prod <= 54'(r_smp * r_wgt);
        end
        if (i_cmd.flatch) begin
            r_noise <= (div_q > DVD_W'(16'hFFFF)) ? 16'hFFFF : div_q[SEED_W-1:0];
        end
    end

    // Octave counter and weight accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_oct <= '0;
            r_wgt <= WGT_W'(1) << WFRAC;
            r_tot <= '0;
            r_sum <= '0;
        end else begin
            if (i_cmd.acc) begin
                r_tot <= r_tot + TOT_W'(r_wgt);
                r_sum <= r_sum + SUM_W'(r_prod);
            end
            if (i_cmd.wstep) begin
                r_wgt <= div_q[WGT_W-1:0];
                r_oct <= r_oct + 1'b1;
            end
        end
    end

    // Shared divider: weight step, then final normalization
    always_comb begin
        div_start = i_cmd.acc | i_cmd.fstart;
        if (i_cmd.fstart) begin
            div_dvd = r_sum + SUM_W'(r_tot >> 1);
            div_dvr = DVR_W'(r_tot);
        end else begin
            div_dvd = DVD_W'({r_wgt, 12'b0});
            div_dvr = DVR_W'(bias);
        end
    end

    ovn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvr),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign o_stat.div_done = div_done;
    assign o_stat.last_oct = (r_oct == oct_last);
    assign o_noise_value   = r_noise;
    assign o_out_x         = r_x;
    assign o_out_y         = r_y;
endmodule

### sv/ovn_ctrl.sv
// Controller FSM: sequences seed reads, interpolation, accumulation and
// a division for each octave, then a final one. Depends on ovn_pkg.
module ovn_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_opcode,
    input  ovn_pkg::t_dp_stat  i_stat,
    output ovn_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy,
    output logic               o_valid
);
    import ovn_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_start && i_opcode == OP_QUERY) n_state = ST_RD0;
            ST_RD0:   n_state = ST_RD1;
            ST_RD1:   n_state = ST_RD2;
            ST_RD2:   n_state = ST_RD3;
            ST_RD3:   n_state = ST_RDL;
            ST_RDL:   n_state = ST_M1;
            ST_M1:    n_state = ST_M2;
            ST_M2:    n_state = ST_M3;
            ST_M3:    n_state = ST_M4;
            ST_M4:    n_state = ST_M5;
            ST_M5:    n_state = ST_ACC;
            ST_ACC:   n_state = ST_WDIV;
            ST_WDIV: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.last_oct ? ST_FDIV : ST_RD0;
                end
            end
            ST_FDIV:  n_state = ST_FWAIT;
            ST_FWAIT: if (i_stat.div_done) n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.wr_seed = i_start && (i_opcode == OP_WRITE);
                o_cmd.load    = i_start && (i_opcode == OP_QUERY);
            end
            ST_RD0: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_idx = CRN_11;
            end
            ST_RD1: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_idx = CRN_12;
                o_cmd.cap_en = 1'b1; o_cmd.cap_idx = CRN_11;
            end
            ST_RD2: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_idx = CRN_21;
                o_cmd.cap_en = 1'b1; o_cmd.cap_idx = CRN_12;
            end
            ST_RD3: begin
                o_cmd.rd_en = 1'b1; o_cmd.rd_idx = CRN_22;
                o_cmd.cap_en = 1'b1; o_cmd.cap_idx = CRN_21;
            end
            ST_RDL: begin
                o_cmd.cap_en = 1'b1; o_cmd.cap_idx = CRN_22;
            end
            ST_M1:    o_cmd.m1 = 1'b1;
            ST_M2:    o_cmd.m2 = 1'b1;
            ST_M3:    o_cmd.m3 = 1'b1;
            ST_M4:    o_cmd.m4 = 1'b1;
            ST_M5:    o_cmd.m5 = 1'b1;
            ST_ACC:   o_cmd.acc = 1'b1;
            ST_WDIV:  o_cmd.wstep = i_stat.div_done;
            ST_FDIV:  o_cmd.fstart = 1'b1;
            ST_FWAIT: o_cmd.flatch = i_stat.div_done;
            ST_OUT:   o_cmd = '0;
            default:  o_cmd = '0;
        endcase
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
endmodule

### sv/octave_value_noise_2d.sv
// Fractal value noise over a 128x128 seed grid. A seed write is taken while idle and does not raise busy.
// A query holds busy through, per octave, the seed reads, interpolation,
// accumulation and the bit-serial weight division, then through the
// normalizing division and the result state; the shared divider does both
// divisions. One item at a time.
// Synchronous active-low reset: octaves 5, bias 2.0; seed RAM is not cleared.
// The result beat is held one cycle under o_valid; the receiver cannot stall.
module octave_value_noise_2d (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_opcode,
    input  logic [ovn_pkg::SIDE_LG-1:0] i_pos_x,
    input  logic [ovn_pkg::SIDE_LG-1:0] i_pos_y,
    input  logic [ovn_pkg::SEED_W-1:0]  i_seed_value,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [ovn_pkg::BIAS_W-1:0]  i_cfg_data,
    output logic                        o_valid,
    output logic [ovn_pkg::SEED_W-1:0]  o_noise_value,
    output logic [ovn_pkg::SIDE_LG-1:0] o_out_x,
    output logic [ovn_pkg::SIDE_LG-1:0] o_out_y
);
    import ovn_pkg::*;
`include "assert_macros.svh"

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ovn_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    ovn_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_seed_value  (i_seed_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_noise_value (o_noise_value),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y)
    );

    // A query beat always starts a busy period; a seed write never does
    `AST_NEXT(a_query_busy, i_clk, i_rst_n, start && !busy && i_opcode == OP_QUERY, busy)
    `AST_NEXT(a_write_idle, i_clk, i_rst_n, start && !busy && i_opcode == OP_WRITE, !busy)
    // A result beat ends the busy period
    `AST_NEXT(a_out_done, i_clk, i_rst_n, o_valid, !busy && !o_valid)
    `AST_IMPLY(a_out_busy, i_clk, i_rst_n, o_valid, busy && $past(busy))
endmodule

### dv/octave_value_noise_2d_test.sv
// Self-checking testbench for octave_value_noise_2d: seed writes, noise
// queries and register writes, checked against an in-bench noise predictor
// or typed-in values. Depends on ovn_pkg and the octave_value_noise_2d RTL.
`timescale 1ns / 1ps

module octave_value_noise_2d_test;
    import ovn_pkg::*;

    localparam int  CLK_HALF   = 4;
    localparam int  DRAIN_WAIT = 700;      // longer than a 7-octave query
    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam int  RAND_PHASES = 8;
    localparam int  PHASE_ITEMS = 172;
    localparam int  AXIS_PTS    = 16;
    localparam int  QUERY_PTS   = 18;

    typedef enum logic {K_CFG, K_ITEM} t_row_kind;

    typedef struct {
        t_row_kind kind;
        logic      op;       // opcode, or register index for K_CFG
        int        x;
        int        y;
        int        data;     // seed value or register value
        bit        chk;      // expected noise typed in
        int        exp_val;
    } t_row;

    typedef struct {
        logic [15:0] noise;
        logic [6:0]  x;
        logic [6:0]  y;
    } t_noise_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_opcode = OP_WRITE;
    logic [6:0]  i_pos_x = '0;
    logic [6:0]  i_pos_y = '0;
    logic [15:0] i_seed_value = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_OCTAVES;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic [15:0] o_noise_value;
    logic [6:0]  o_out_x;
    logic [6:0]  o_out_y;

    // Mirror of block state
    logic [15:0] seed_mirror [SIDE*SIDE];
    logic [2:0]  octaves_cfg = OCT_RESET;
    logic [15:0] bias_cfg = BIAS_RESET;

    t_noise_beat noise_pending[$];
    int          err_cnt = 0;
    longint      cycle_cnt = 0;
    bit          no_idle = 1'b0;

    octave_value_noise_2d DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_seed_value(i_seed_value), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_noise_value(o_noise_value),
        .o_out_x(o_out_x), .o_out_y(o_out_y)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Grid coordinates seeded up front: every corner of any octave around
    // a query coordinate from query_pt lands on one of these
    function automatic int axis_pt(int k);
        if (k <= 8) return 2 * k;
        case (k)
            9:       return 32;
            10:      return 64;
            11:      return 96;
            12:      return 112;
            13:      return 120;
            14:      return 124;
            default: return 126;
        endcase
    endfunction

    // Query coordinates: 0..15, then 126 and 127
    function automatic int query_pt(int k);
        return (k < 16) ? k : k + 110;
    endfunction

    // Fractal value noise, weights with 24 fraction bits
    function automatic logic [15:0] noise_at(int x, int y);
        longint unsigned bias, wgt, total, acc, top, bot, smp, r, p, dx, dy;
        int octs, x1, y1, x2, y2;
        octs  = (octaves_cfg == 0) ? 1 : octaves_cfg;
        bias  = (bias_cfg < BIAS_MIN) ? BIAS_MIN : bias_cfg;
        wgt   = 64'd1 << WFRAC;
        total = 0;
        acc   = 0;
        for (int o = 0; o < octs; o++) begin
            p = SIDE >> o;
            if (p == 0) p = 1;
            x1 = (x / p) * p;
            y1 = (y / p) * p;
            x2 = (x1 + p) % SIDE;
            y2 = (y1 + p) % SIDE;
            dx = x - x1;
            dy = y - y1;
            top = (p - dx) * seed_mirror[y1*SIDE + x1] + dx * seed_mirror[y1*SIDE + x2];
            bot = (p - dx) * seed_mirror[y2*SIDE + x1] + dx * seed_mirror[y2*SIDE + x2];
            smp = ((p - dy) * top + dy * bot) / (p * p);
            total += wgt;
            acc   += smp * wgt;
            wgt    = (wgt << 12) / bias;
        end
        r = (acc + total / 2) / total;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    // One command beat; returns at the edge that accepts it
    task automatic send_cmd(logic op, int x, int y, int seed, bit chk, int exp_val);
        t_noise_beat nb;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_pos_x      <= x[6:0];
        i_pos_y      <= y[6:0];
        i_seed_value <= seed[15:0];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (op == OP_WRITE) begin
            seed_mirror[y[6:0]*SIDE + x[6:0]] = seed[15:0];
        end else begin
            nb.noise = chk ? exp_val[15:0] : noise_at(x[6:0], y[6:0]);
            nb.x = x[6:0];
            nb.y = y[6:0];
            noise_pending.push_back(nb);
        end
    endtask

    // Register write, only once the block has gone quiet
    task automatic cfg_write(logic idx, int data);
        start <= 1'b0;
        @(posedge i_clk);
        while (noise_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[15:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_OCTAVES) octaves_cfg = data[2:0];
        else bias_cfg = data[15:0];
    endtask

    // Result beat checker
    always @(posedge i_clk) begin
        t_noise_beat nb;
        if (i_rst_n && o_valid) begin
            if (noise_pending.size() == 0) begin
                $display("%0t: unexpected beat noise=%0d x=%0d y=%0d", $time,
                         o_noise_value, o_out_x, o_out_y);
                err_cnt++;
            end else begin
                nb = noise_pending.pop_front();
                if (o_noise_value !== nb.noise) begin
                    $display("%0t: noise expected %0d actual %0d", $time, nb.noise,
                             o_noise_value);
                    err_cnt++;
                end
                if (o_out_x !== nb.x) begin
                    $display("%0t: out_x expected %0d actual %0d", $time, nb.x, o_out_x);
                    err_cnt++;
                end
                if (o_out_y !== nb.y) begin
                    $display("%0t: out_y expected %0d actual %0d", $time, nb.y, o_out_y);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL octave_value_noise_2d");
            $finish;
        end
    end

    // Directed rows: single-octave corner reads can be read off directly
    t_row dir_rows[24] = '{
        '{K_CFG,  CFG_OCTAVES, 0, 0, 1, 0, 0},
        '{K_ITEM, OP_WRITE, 0, 0, 65535, 0, 0},
        '{K_ITEM, OP_QUERY, 0, 0, 0, 1, 65535},
        '{K_ITEM, OP_WRITE, 0, 0, 0, 0, 0},
        '{K_ITEM, OP_QUERY, 0, 0, 0, 1, 0},
        '{K_ITEM, OP_WRITE, 127, 127, 65535, 0, 0},
        '{K_ITEM, OP_QUERY, 127, 127, 0, 0, 0},
        '{K_CFG,  CFG_OCTAVES, 0, 0, 0, 0, 0},
        '{K_ITEM, OP_QUERY, 0, 0, 0, 1, 0},
        '{K_ITEM, OP_QUERY, 127, 0, 0, 0, 0},
        '{K_CFG,  CFG_OCTAVES, 0, 0, 7, 0, 0},
        '{K_ITEM, OP_QUERY, 127, 127, 0, 0, 0},
        '{K_ITEM, OP_QUERY, 0, 127, 0, 0, 0},
        '{K_CFG,  CFG_BIAS, 0, 0, 0, 0, 0},
        '{K_ITEM, OP_QUERY, 8, 8, 0, 0, 0},
        '{K_CFG,  CFG_BIAS, 0, 0, 818, 0, 0},
        '{K_ITEM, OP_QUERY, 1, 1, 0, 0, 0},
        '{K_CFG,  CFG_BIAS, 0, 0, 819, 0, 0},
        '{K_ITEM, OP_QUERY, 127, 1, 0, 0, 0},
        '{K_CFG,  CFG_BIAS, 0, 0, 65535, 0, 0},
        '{K_ITEM, OP_WRITE, 127, 0, 65535, 0, 0},
        '{K_ITEM, OP_QUERY, 126, 1, 0, 0, 0},
        '{K_CFG,  CFG_OCTAVES, 0, 0, 3, 0, 0},
        '{K_ITEM, OP_QUERY, 13, 6, 0, 0, 0}
    };

    initial begin
        int oct_pick, bias_pick;
        logic rop;
        int rx, ry;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Seed every grid point that a query corner can land on
        no_idle = 1'b1;
        for (int i = 0; i < AXIS_PTS * AXIS_PTS; i++)
            send_cmd(OP_WRITE, axis_pt(i % AXIS_PTS), axis_pt(i / AXIS_PTS),
                     $urandom_range(0, 65535), 0, 0);
        no_idle = 1'b0;

        // Directed part
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == K_CFG)
                cfg_write(dir_rows[i].op, dir_rows[i].data);
            else
                send_cmd(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y,
                         dir_rows[i].data, dir_rows[i].chk, dir_rows[i].exp_val);
        end

        // Random phases, each with its own register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin oct_pick = 7; bias_pick = 819; end
                1: begin oct_pick = 1; bias_pick = 65535; end
                2: begin oct_pick = 0; bias_pick = $urandom_range(0, 818); end
                default: begin
                    oct_pick  = $urandom_range(0, 7);
                    bias_pick = $urandom_range(0, 65535);
                end
            endcase
            cfg_write(CFG_OCTAVES, oct_pick);
            cfg_write(CFG_BIAS, bias_pick);
            if (ph == RAND_PHASES - 1) no_idle = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                rop = $urandom_range(0, 1);
                if (rop) begin
                    rx = query_pt($urandom_range(0, QUERY_PTS - 1));
                    ry = query_pt($urandom_range(0, QUERY_PTS - 1));
                end else begin
                    rx = $urandom_range(0, 127);
                    ry = $urandom_range(0, 127);
                end
                send_cmd(rop ? OP_QUERY : OP_WRITE, rx, ry,
                         $urandom_range(0, 65535), 0, 0);
            end
        end
        start <= 1'b0;

        // Drain
        while (noise_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS octave_value_noise_2d");
        end else begin
            $display("FAIL octave_value_noise_2d");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/ovn_pkg.sv
sv/ovn_ram.sv
sv/ovn_div.sv
sv/ovn_dp.sv
sv/ovn_ctrl.sv
sv/octave_value_noise_2d.sv
dv/octave_value_noise_2d_test.sv
